// File: rtl/core/fpr_pkg.sv
`timescale 1ns / 1ps

package fpr_pkg;

   // Line control characters
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_ETX = 8'h03;
   localparam logic [7:0] CH_DLE = 8'h10;

   // Known command letters
   localparam logic [7:0] CMD_S_UP = 8'h53;
   localparam logic [7:0] CMD_S_LO = 8'h73;
   localparam logic [7:0] CMD_G_UP = 8'h47;
   localparam logic [7:0] CMD_G_LO = 8'h67;
   localparam logic [7:0] CMD_P_UP = 8'h50;
   localparam logic [7:0] CMD_P_LO = 8'h70;

   typedef enum logic [3:0] {
      PART_IDLE = 4'd0,
      PART_ADDR = 4'd1,
      PART_ID   = 4'd2,
      PART_CMD  = 4'd3,
      PART_STAT = 4'd4,
      PART_SIZE = 4'd5,
      PART_DATA = 4'd6,
      PART_CSUM = 4'd7,
      PART_DONE = 4'd8
   } part_type;

   localparam logic [1:0] ST_IDLE       = 2'd0;
   localparam logic [1:0] ST_INCOMPLETE = 2'd1;
   localparam logic [1:0] ST_CORRECT    = 2'd2;
   localparam logic [1:0] ST_ERROR      = 2'd3;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_CMD   = 3'd1;
   localparam logic [2:0] ERR_SIZE      = 3'd2;
   localparam logic [2:0] ERR_EXTRA     = 3'd3;
   localparam logic [2:0] ERR_EARLY_END = 3'd4;
   localparam logic [2:0] ERR_CHECKSUM  = 3'd5;

   localparam logic [2:0] KIND_ADDR   = 3'd0;
   localparam logic [2:0] KIND_ID     = 3'd1;
   localparam logic [2:0] KIND_CMD    = 3'd2;
   localparam logic [2:0] KIND_STAT   = 3'd3;
   localparam logic [2:0] KIND_SIZE   = 3'd4;
   localparam logic [2:0] KIND_DATA   = 3'd5;
   localparam logic [2:0] KIND_CSUM   = 3'd6;

   // Frame context that does not depend on the payload limit
   typedef struct packed {
      part_type   part;
      logic       escape;
      logic [7:0] xor_sum;
      logic [7:0] checksum;
   } ctx_type;

   // One result word
   typedef struct packed {
      logic [1:0] frame_status;
      logic [2:0] error_cause;
      logic       byte_valid;
      logic [2:0] field_kind;
      logic [7:0] byte_value;
      logic [5:0] data_index;
   } rsp_type;

   function automatic logic command_known(input logic [7:0] c);
      return (c == CMD_S_UP) || (c == CMD_S_LO) || (c == CMD_G_UP) ||
             (c == CMD_G_LO) || (c == CMD_P_UP) || (c == CMD_P_LO);
   endfunction

endpackage

// File: rtl/core/fpr_step.sv
`timescale 1ns / 1ps

module fpr_step import fpr_pkg::*; #(
   parameter int MAX_PAYLOAD = 64,
   parameter int LEN_W       = 6
) (
   input  logic [7:0]       raw_byte,
   input  ctx_type          ctx_cur,
   input  logic [LEN_W-1:0] idx_cur,
   input  logic [LEN_W-1:0] len_cur,
   output ctx_type          ctx_nxt,
   output logic [LEN_W-1:0] idx_nxt,
   output logic [LEN_W-1:0] len_nxt,
   output rsp_type          rsp
);

   logic [7:0]     dec_byte;
   logic [LEN_W:0] idx_inc;
   logic [7:0]     idx_wide;

   always_comb begin
      dec_byte = ctx_cur.escape ? (raw_byte - CH_DLE) : raw_byte;
      idx_inc  = {1'b0, idx_cur} + {{LEN_W{1'b0}}, 1'b1};
      idx_wide = 8'(idx_cur);

      ctx_nxt = ctx_cur;
      idx_nxt = idx_cur;
      len_nxt = len_cur;
      rsp     = '0;

      if (raw_byte == CH_STX) begin
         ctx_nxt      = '0;
         ctx_nxt.part = PART_ADDR;
         idx_nxt      = '0;
         len_nxt      = '0;
         rsp.frame_status = ST_INCOMPLETE;
      end else if (raw_byte == CH_ETX) begin
         ctx_nxt = '0;
         idx_nxt = '0;
         len_nxt = '0;
         if (ctx_cur.part == PART_DONE && ctx_cur.xor_sum == ctx_cur.checksum) begin
            rsp.frame_status = ST_CORRECT;
         end else begin
            rsp.frame_status = ST_ERROR;
            rsp.error_cause  = (ctx_cur.part == PART_DONE) ? ERR_CHECKSUM : ERR_EARLY_END;
         end
      end else if (raw_byte == CH_DLE) begin
         ctx_nxt.escape   = 1'b1;
         rsp.frame_status = (ctx_cur.part == PART_IDLE) ? ST_IDLE : ST_INCOMPLETE;
      end else begin
         ctx_nxt.escape = 1'b0;
         case (ctx_cur.part)
            PART_IDLE: begin
               rsp.frame_status = ST_IDLE;
            end
            PART_ADDR, PART_ID, PART_STAT: begin
               ctx_nxt.xor_sum  = ctx_cur.xor_sum ^ dec_byte;
               ctx_nxt.part     = part_type'(ctx_cur.part + 4'd1);
               rsp.frame_status = ST_INCOMPLETE;
               rsp.byte_valid   = 1'b1;
               rsp.field_kind   = (ctx_cur.part == PART_ADDR) ? KIND_ADDR :
                                  (ctx_cur.part == PART_ID)   ? KIND_ID : KIND_STAT;
               rsp.byte_value   = dec_byte;
            end
            PART_CMD: begin
               if (!command_known(dec_byte)) begin
                  ctx_nxt = '0;
                  idx_nxt = '0;
                  len_nxt = '0;
                  rsp.frame_status = ST_ERROR;
                  rsp.error_cause  = ERR_BAD_CMD;
               end else begin
                  ctx_nxt.xor_sum  = ctx_cur.xor_sum ^ dec_byte;
                  ctx_nxt.part     = PART_STAT;
                  rsp.frame_status = ST_INCOMPLETE;
                  rsp.byte_valid   = 1'b1;
                  rsp.field_kind   = KIND_CMD;
                  rsp.byte_value   = dec_byte;
               end
            end
            PART_SIZE: begin
               if ({1'b0, dec_byte} >= 9'(MAX_PAYLOAD)) begin
                  ctx_nxt = '0;
                  idx_nxt = '0;
                  len_nxt = '0;
                  rsp.frame_status = ST_ERROR;
                  rsp.error_cause  = ERR_SIZE;
               end else begin
                  // The size is below the limit, so it fits the length register.
                  ctx_nxt.xor_sum  = ctx_cur.xor_sum ^ dec_byte;
                  len_nxt          = dec_byte[LEN_W-1:0];
                  idx_nxt          = '0;
                  ctx_nxt.part     = (dec_byte == 8'd0) ? PART_CSUM : PART_DATA;
                  rsp.frame_status = ST_INCOMPLETE;
                  rsp.byte_valid   = 1'b1;
                  rsp.field_kind   = KIND_SIZE;
                  rsp.byte_value   = dec_byte;
               end
            end
            PART_DATA: begin
               ctx_nxt.xor_sum  = ctx_cur.xor_sum ^ dec_byte;
               idx_nxt          = idx_inc[LEN_W-1:0];
               if (idx_inc >= {1'b0, len_cur}) begin
                  ctx_nxt.part = PART_CSUM;
               end
               rsp.frame_status = ST_INCOMPLETE;
               rsp.byte_valid   = 1'b1;
               rsp.field_kind   = KIND_DATA;
               rsp.byte_value   = dec_byte;
               rsp.data_index   = idx_wide[5:0];
            end
            PART_CSUM: begin
               ctx_nxt.checksum = dec_byte;
               ctx_nxt.part     = PART_DONE;
               rsp.frame_status = ST_INCOMPLETE;
               rsp.byte_valid   = 1'b1;
               rsp.field_kind   = KIND_CSUM;
               rsp.byte_value   = dec_byte;
            end
            default: begin
               // Any byte after the checksum other than a start, end or escape marker.
               ctx_nxt = '0;
               idx_nxt = '0;
               len_nxt = '0;
               rsp.frame_status = ST_ERROR;
               rsp.error_cause  = ERR_EXTRA;
            end
         endcase
      end
   end

endmodule

// File: rtl/core/framed_packet_receiver_core.sv
`timescale 1ns / 1ps

// Receiver for STX/ETX/DLE framed packets with an XOR checksum. Each input word
// is one raw line byte and produces exactly one result word, registered, in the
// cycle after the byte is taken. One byte is accepted every cycle; req_ready
// only drops while the result register holds a word that the sink has not yet
// taken. The frame state and the result register are the only storage, and
// the per-byte decode is a single pass of compare and XOR logic.
module framed_packet_receiver_core import fpr_pkg::*; #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_raw_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_frame_status,
   output logic [2:0] rsp_error_cause,
   output logic       rsp_byte_valid,
   output logic [2:0] rsp_field_kind,
   output logic [7:0] rsp_byte_value,
   output logic [5:0] rsp_data_index
);

   localparam int LEN_W = (MAX_PAYLOAD > 2) ? $clog2(MAX_PAYLOAD) : 1;

   ctx_type          ctx_ff, ctx_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff;
   logic             accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   fpr_step #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .LEN_W       (LEN_W)
   ) u_step (
      .raw_byte (req_raw_byte),
      .ctx_cur  (ctx_ff),
      .idx_cur  (idx_ff),
      .len_cur  (len_ff),
      .ctx_nxt  (ctx_in),
      .idx_nxt  (idx_in),
      .len_nxt  (len_in),
      .rsp      (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff       <= '0;
         idx_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            ctx_ff <= ctx_in;
            idx_ff <= idx_in;
            len_ff <= len_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = rsp_ff.frame_status;
   assign rsp_error_cause  = rsp_ff.error_cause;
   assign rsp_byte_valid   = rsp_ff.byte_valid;
   assign rsp_field_kind   = rsp_ff.field_kind;
   assign rsp_byte_value   = rsp_ff.byte_value;
   assign rsp_data_index   = rsp_ff.data_index;

endmodule

// File: rtl/core/fpr_checker.sv
`timescale 1ns / 1ps

module fpr_checker import fpr_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_raw_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_frame_status,
   input logic [2:0] rsp_error_cause,
   input logic       rsp_byte_valid,
   input logic [2:0] rsp_field_kind,
   input logic [7:0] rsp_byte_value,
   input logic [5:0] rsp_data_index
);

   // A stalled result word must stay valid and keep its status and byte value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_status) &&
      $stable(rsp_byte_value))
      else $error("result word changed while stalled");

   // A cause is only reported with an error status.
   a_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_cause != ERR_NONE |-> rsp_frame_status == ST_ERROR)
      else $error("error cause without error status");

   // No delivered byte means empty byte fields.
   a_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |->
      rsp_field_kind == KIND_ADDR && rsp_byte_value == 8'd0 && rsp_data_index == 6'd0)
      else $error("byte fields set without a delivered byte");

   // A start marker always yields an incomplete frame word next.
   a_stx: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_raw_byte == CH_STX |=>
      rsp_valid && rsp_frame_status == ST_INCOMPLETE && !rsp_byte_valid)
      else $error("start marker not answered as incomplete frame");

   // A data index is only given for data bytes.
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_index != 6'd0 |->
      rsp_byte_valid && rsp_field_kind == KIND_DATA)
      else $error("data index outside a data byte");

endmodule

bind framed_packet_receiver_core fpr_checker u_fpr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_raw_byte     (req_raw_byte),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_frame_status (rsp_frame_status),
   .rsp_error_cause  (rsp_error_cause),
   .rsp_byte_valid   (rsp_byte_valid),
   .rsp_field_kind   (rsp_field_kind),
   .rsp_byte_value   (rsp_byte_value),
   .rsp_data_index   (rsp_data_index)
);

// File: tb/framed_packet_receiver_core_tb.sv
`timescale 1ns / 1ps

module framed_packet_receiver_core_tb import fpr_pkg::*; ();

   localparam int PAYLOAD_LIMIT = 64;
   localparam int RANDOM_BYTES  = 590;
   localparam int TAIL_BYTES    = 120;

   typedef enum {
      FAULT_NONE,
      FAULT_CHECKSUM,
      FAULT_EARLY_END,
      FAULT_EXTRA,
      FAULT_RESTART
   } fault_type;

   // Tracks the receiver's frame state and holds the result words still owed by the block.
   class frame_scoreboard;
      part_type   part;
      bit         escape_pending;
      logic [7:0] payload_index;
      logic [7:0] payload_length;
      logic [7:0] running_xor;
      logic [7:0] received_checksum;
      rsp_type    expected_words[$];
      int         error_count;
      int         words_checked;
      int         frames_passed;
      int         frames_rejected;

      function new();
         clear_frame();
         escape_pending = 1'b0;
         error_count = 0;
         words_checked = 0;
         frames_passed = 0;
         frames_rejected = 0;
      endfunction

      function void clear_frame();
         part = PART_IDLE;
         escape_pending = 1'b0;
         payload_index = '0;
         payload_length = '0;
         running_xor = '0;
         received_checksum = '0;
      endfunction

      function rsp_type decode_byte(input logic [7:0] raw);
         rsp_type    word;
         logic [7:0] b;
         word = '0;
         b = raw;
         if (raw == CH_STX) begin
            clear_frame();
            part = PART_ADDR;
            word.frame_status = ST_INCOMPLETE;
            return word;
         end
         if (raw == CH_ETX) begin
            if (part == PART_DONE && running_xor == received_checksum) begin
               word.frame_status = ST_CORRECT;
            end else begin
               word.frame_status = ST_ERROR;
               word.error_cause = (part == PART_DONE) ? ERR_CHECKSUM : ERR_EARLY_END;
            end
            clear_frame();
            return word;
         end
         if (raw == CH_DLE) begin
            escape_pending = 1'b1;
            word.frame_status = (part == PART_IDLE) ? ST_IDLE : ST_INCOMPLETE;
            return word;
         end
         // A stuffed byte arrives raised by the escape offset.
         if (escape_pending) begin
            b = raw - CH_DLE;
            escape_pending = 1'b0;
         end
         word.frame_status = ST_INCOMPLETE;
         case (part)
            PART_IDLE: begin
               word.frame_status = ST_IDLE;
            end
            PART_ADDR, PART_ID, PART_STAT: begin
               running_xor ^= b;
               word.byte_valid = 1'b1;
               word.byte_value = b;
               word.field_kind = (part == PART_ADDR) ? KIND_ADDR :
                                 (part == PART_ID)   ? KIND_ID : KIND_STAT;
               part = part_type'(part + 4'd1);
            end
            PART_CMD: begin
               if (!(b inside {CMD_S_UP, CMD_S_LO, CMD_G_UP, CMD_G_LO, CMD_P_UP, CMD_P_LO}))
               begin
                  clear_frame();
                  word.frame_status = ST_ERROR;
                  word.error_cause = ERR_BAD_CMD;
               end else begin
                  running_xor ^= b;
                  word.byte_valid = 1'b1;
                  word.byte_value = b;
                  word.field_kind = KIND_CMD;
                  part = PART_STAT;
               end
            end
            PART_SIZE: begin
               if (b >= PAYLOAD_LIMIT) begin
                  clear_frame();
                  word.frame_status = ST_ERROR;
                  word.error_cause = ERR_SIZE;
               end else begin
                  running_xor ^= b;
                  payload_length = b;
                  payload_index = '0;
                  part = (b == 8'd0) ? PART_CSUM : PART_DATA;
                  word.byte_valid = 1'b1;
                  word.byte_value = b;
                  word.field_kind = KIND_SIZE;
               end
            end
            PART_DATA: begin
               running_xor ^= b;
               word.byte_valid = 1'b1;
               word.byte_value = b;
               word.field_kind = KIND_DATA;
               word.data_index = payload_index[5:0];
               payload_index = payload_index + 8'd1;
               if (payload_index >= payload_length) begin
                  part = PART_CSUM;
               end
            end
            PART_CSUM: begin
               received_checksum = b;
               part = PART_DONE;
               word.byte_valid = 1'b1;
               word.byte_value = b;
               word.field_kind = KIND_CSUM;
            end
            default: begin
               clear_frame();
               word.frame_status = ST_ERROR;
               word.error_cause = ERR_EXTRA;
            end
         endcase
         return word;
      endfunction

      function void note_byte(input logic [7:0] raw);
         expected_words.push_back(decode_byte(raw));
      endfunction

      function void compare_field(input string field_name, input int unsigned want,
                                  input int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field_name, want, got);
            error_count++;
         end
      endfunction

      function void check_word(input rsp_type got);
         rsp_type want;
         if (expected_words.size() == 0) begin
            $error("result word arrived with none outstanding");
            error_count++;
            return;
         end
         want = expected_words.pop_front();
         words_checked++;
         if (want.frame_status == ST_CORRECT) frames_passed++;
         if (want.frame_status == ST_ERROR) frames_rejected++;
         compare_field("frame_status", want.frame_status, got.frame_status);
         compare_field("error_cause", want.error_cause, got.error_cause);
         compare_field("byte_valid", want.byte_valid, got.byte_valid);
         compare_field("field_kind", want.field_kind, got.field_kind);
         compare_field("byte_value", want.byte_value, got.byte_value);
         compare_field("data_index", want.data_index, got.data_index);
      endfunction

      function void flag_leftovers();
         if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            error_count += expected_words.size();
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_raw_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_frame_status;
   logic [2:0] rsp_error_cause;
   logic       rsp_byte_valid;
   logic [2:0] rsp_field_kind;
   logic [7:0] rsp_byte_value;
   logic [5:0] rsp_data_index;

   frame_scoreboard scoreboard;
   logic [7:0]      line_bytes[$];
   int              bytes_sent = 0;
   bit              idling_on = 1'b1;
   bit              tail_phase = 1'b0;

   logic [7:0] known_cmds[6] = '{CMD_S_UP, CMD_S_LO, CMD_G_UP, CMD_G_LO, CMD_P_UP, CMD_P_LO};
   logic [7:0] awkward_bytes[8] = '{CH_STX, CH_ETX, CH_DLE, 8'h00, 8'hFF, 8'hF2, 8'hF3, 8'h12};

   framed_packet_receiver_core #(
      .MAX_PAYLOAD(PAYLOAD_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_raw_byte(req_raw_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_frame_status(rsp_frame_status),
      .rsp_error_cause(rsp_error_cause),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_field_kind(rsp_field_kind),
      .rsp_byte_value(rsp_byte_value),
      .rsp_data_index(rsp_data_index)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("framed_packet_receiver_core test failed");
      $finish;
   end

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 7) == 0) return awkward_bytes[$urandom_range(0, 7)];
      return 8'($urandom_range(0, 255));
   endfunction

   // Control characters must be stuffed; other bytes are stuffed now and then too,
   // provided the raised value does not itself land on a control character.
   function automatic void push_decoded(input logic [7:0] b);
      logic [7:0] raised;
      raised = b + CH_DLE;
      if (b == CH_STX || b == CH_ETX || b == CH_DLE ||
          ($urandom_range(0, 7) == 0 && raised != CH_STX && raised != CH_ETX &&
           raised != CH_DLE)) begin
         if ($urandom_range(0, 15) == 0) line_bytes.push_back(CH_DLE);
         line_bytes.push_back(CH_DLE);
         line_bytes.push_back(raised);
      end else begin
         line_bytes.push_back(b);
      end
   endfunction

   function automatic void build_frame(input logic [7:0] addr, input logic [7:0] id,
                                       input logic [7:0] cmd, input logic [7:0] stat,
                                       input logic [7:0] size, input fault_type fault);
      logic [7:0] sum;
      logic [7:0] value;
      int         start;
      int         cut;
      start = line_bytes.size();
      sum = addr ^ id ^ cmd ^ stat ^ size;
      line_bytes.push_back(CH_STX);
      push_decoded(addr);
      push_decoded(id);
      push_decoded(cmd);
      if (!(cmd inside {CMD_S_UP, CMD_S_LO, CMD_G_UP, CMD_G_LO, CMD_P_UP, CMD_P_LO})) return;
      push_decoded(stat);
      push_decoded(size);
      if (size >= PAYLOAD_LIMIT) return;
      for (int i = 0; i < size; i++) begin
         value = pick_byte();
         sum ^= value;
         push_decoded(value);
      end
      if (fault == FAULT_CHECKSUM) sum ^= 8'(1 << $urandom_range(0, 7));
      push_decoded(sum);
      if (fault == FAULT_EXTRA) push_decoded(pick_byte());
      line_bytes.push_back(CH_ETX);
      if (fault == FAULT_EARLY_END || fault == FAULT_RESTART) begin
         cut = $urandom_range(start + 1, line_bytes.size() - 3);
         line_bytes = line_bytes[0:cut];
         if (fault == FAULT_EARLY_END) line_bytes.push_back(CH_ETX);
      end
   endfunction

   function automatic logic [7:0] pick_size();
      if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 8));
      return 8'($urandom_range(9, PAYLOAD_LIMIT - 1));
   endfunction

   function automatic void build_good_frame(input fault_type fault);
      build_frame(pick_byte(), pick_byte(), known_cmds[$urandom_range(0, 5)], pick_byte(),
                  pick_size(), fault);
   endfunction

   task automatic send_byte(input logic [7:0] raw);
      if (idling_on && !tail_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_byte <= raw;
      do @(posedge clock); while (!req_ready);
      scoreboard.note_byte(raw);
      bytes_sent++;
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
      line_bytes.delete();
   endtask

   // Result side: accept words and stall in short random bursts.
   initial begin
      rsp_type got;
      int      stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.frame_status = rsp_frame_status;
            got.error_cause = rsp_error_cause;
            got.byte_valid = rsp_byte_valid;
            got.field_kind = rsp_field_kind;
            got.byte_value = rsp_byte_value;
            got.data_index = rsp_data_index;
            scoreboard.check_word(got);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling_on && !tail_phase && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [7:0] bad_cmd;
      int         directed_count;
      int         choice;
      int         guard;
      scoreboard = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Line noise with no frame open, including escapes that are never used.
      line_bytes = '{8'h00, 8'hFF, CH_DLE, 8'h45, CH_DLE, CH_DLE, 8'h22, CH_DLE, CH_ETX, CH_ETX};
      send_line();
      // Zero-length frame with extreme header bytes, then the longest legal payload.
      build_frame(8'h00, 8'hFF, CMD_S_UP, CH_DLE, 8'd0, FAULT_NONE);
      build_frame(8'hFF, 8'h00, CMD_P_LO, 8'hF3, 8'(PAYLOAD_LIMIT - 1), FAULT_NONE);
      // Rejected command and rejected sizes.
      build_frame(8'h01, 8'h02, 8'h00, 8'h00, 8'd0, FAULT_NONE);
      build_frame(8'h01, 8'h02, 8'h58, 8'h00, 8'd0, FAULT_NONE);
      build_frame(8'h11, 8'h22, CMD_G_UP, 8'h33, 8'(PAYLOAD_LIMIT), FAULT_NONE);
      build_frame(8'h11, 8'h22, CMD_G_LO, 8'h33, 8'hFF, FAULT_NONE);
      build_frame(8'h44, 8'h55, CMD_S_LO, 8'h66, 8'd2, FAULT_EXTRA);
      build_frame(8'h44, 8'h55, CMD_P_UP, 8'h66, 8'd3, FAULT_CHECKSUM);
      build_frame(8'h77, 8'h88, CMD_S_UP, 8'h99, 8'd4, FAULT_EARLY_END);
      // A frame cut short by a fresh start, escape pending included.
      line_bytes.push_back(CH_STX);
      line_bytes.push_back(8'hAA);
      line_bytes.push_back(CH_DLE);
      build_frame(8'h5A, 8'hA5, CMD_G_LO, 8'h0F, 8'd1, FAULT_NONE);
      send_line();
      directed_count = bytes_sent;

      while (bytes_sent < directed_count + RANDOM_BYTES) begin
         tail_phase = (bytes_sent >= directed_count + RANDOM_BYTES - TAIL_BYTES);
         idling_on = ($urandom_range(0, 3) != 0);
         choice = $urandom_range(0, 99);
         if (choice < 70) begin
            build_good_frame(FAULT_NONE);
         end else if (choice < 77) begin
            build_good_frame(FAULT_CHECKSUM);
         end else if (choice < 82) begin
            build_good_frame(FAULT_EARLY_END);
         end else if (choice < 86) begin
            build_good_frame(FAULT_EXTRA);
         end else if (choice < 90) begin
            do bad_cmd = 8'($urandom_range(0, 255));
            while (bad_cmd inside {CMD_S_UP, CMD_S_LO, CMD_G_UP, CMD_G_LO, CMD_P_UP, CMD_P_LO});
            build_frame(pick_byte(), pick_byte(), bad_cmd, 8'h00, 8'd0, FAULT_NONE);
         end else if (choice < 93) begin
            build_frame(pick_byte(), pick_byte(), known_cmds[$urandom_range(0, 5)], pick_byte(),
                        8'($urandom_range(PAYLOAD_LIMIT, 255)), FAULT_NONE);
         end else if (choice < 96) begin
            build_good_frame(FAULT_RESTART);
            build_good_frame(FAULT_NONE);
         end else begin
            repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(0, 255)));
         end
         send_line();
      end
      req_valid <= 1'b0;

      guard = 0;
      while (scoreboard.expected_words.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      scoreboard.flag_leftovers();

      $display("Sent %0d line bytes and checked %0d result words.", bytes_sent,
               scoreboard.words_checked);
      $display("Frames closed: %0d accepted, %0d rejected.", scoreboard.frames_passed,
               scoreboard.frames_rejected);
      if (scoreboard.error_count == 0) begin
         $display("framed_packet_receiver_core test passed");
      end else begin
         $display("framed_packet_receiver_core test failed");
      end
      $finish;
   end

endmodule
